@@ rtl/wbpp_pkg.sv @@
`timescale 1ns / 1ps

package wbpp_pkg;

	localparam int unsigned POS_W     = 24;
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 24;
	localparam int unsigned BIN_OUT_W = 8;
	localparam int unsigned CNT_OUT_W = 9;
	localparam int unsigned CHAN_W    = 2;

	typedef logic [POS_W-1:0]           pos_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CHAN_W-1:0]          chan_t;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic REC_BIN   = 1'b0;
	localparam logic REC_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'b1;

	localparam chan_t CHAN_MONO   = 2'd1;
	localparam chan_t CHAN_STEREO = 2'd2;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = -16'sh8000;

endpackage

@@ rtl/waveform_bin_peak_publisher.sv @@
`timescale 1ns / 1ps

// Min/max overview builder for a recorded stereo buffer.
// Input channel (in_valid/in_ready) carries one frame or a clear command per beat.
// Output channel (out_valid/out_ready) carries publish records; an item yields
// zero, one or two records, and last marks the final record of an item.
// Configuration channel (cfg_valid/cfg_ready) is always ready; index 0 sets
// the buffer capacity in frames, index 1 the channel count.
// A frame's first record is loaded after these steps from the accepted beat:
// the position is scaled, the restoring divider for position * BIN_COUNT /
// capacity develops its log2(BIN_COUNT) quotient bits one at a time, the bin
// is updated and the record is emitted. A second record follows once the
// receiver has taken the first. in_ready returns once the last record is
// loaded, or after the bin update for a frame with no record. A clear goes
// straight to emitting its record, and an ignored frame leaves in_ready high.
// in_ready is low while an item is being worked on; one finished record can
// wait in the output register while the next item is already accepted.
// When the receiver stalls, the block holds the pending record and waits
// before loading the next one, so nothing is dropped.
// Reset clears the overview state, sets capacity to zero (all frames ignored)
// and the channel count to stereo.
module waveform_bin_peak_publisher #(
	parameter int unsigned BIN_COUNT        = 256,
	parameter int unsigned PUBLISH_INTERVAL = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wbpp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wbpp_pkg::CFG_DAT_W-1:0]   cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             command,
	input  logic                             frame_written,
	input  wbpp_pkg::pos_t                   frame_offset,
	input  wbpp_pkg::sample_t                left_sample,
	input  wbpp_pkg::sample_t                right_sample,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             record_kind,
	output logic [wbpp_pkg::BIN_OUT_W-1:0]   bin_index,
	output wbpp_pkg::sample_t                left_low,
	output wbpp_pkg::sample_t                left_high,
	output wbpp_pkg::sample_t                right_low,
	output wbpp_pkg::sample_t                right_high,
	output logic [wbpp_pkg::CNT_OUT_W-1:0]   valid_bin_count,
	output wbpp_pkg::chan_t                  reported_channels,
	output logic                             last
);

	import wbpp_pkg::*;

	localparam int unsigned QW = $clog2(BIN_COUNT);
	localparam int unsigned CW = $clog2(BIN_COUNT + 1);
	localparam int unsigned FW = $clog2(PUBLISH_INTERVAL + 1);
	localparam int unsigned SW = $clog2(QW + 1);
	localparam int unsigned NW = POS_W + QW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_UPD,
		S_EMIT
	} state_t;

	state_t state_q;

	pos_t            cap_q;
	chan_t           chan_cfg_q;

	pos_t            pos_q;
	sample_t         l_q;
	sample_t         r_q;
	logic            clamp_q;
	logic [POS_W-1:0] rem_q;
	logic [QW-1:0]   lo_q;
	logic [QW-1:0]   quo_q;
	logic [SW-1:0]   step_q;

	logic [QW-1:0]   open_bin_q;
	logic            active_q;
	sample_t         lmin_q;
	sample_t         lmax_q;
	sample_t         rmin_q;
	sample_t         rmax_q;
	logic [CW-1:0]   opened_q;
	logic [FW-1:0]   fse_q;

	logic            pend_clr_q;
	logic            pend_old_q;
	logic            pend_int_q;
	logic [QW-1:0]   old_bin_q;
	sample_t         old_lmin_q;
	sample_t         old_lmax_q;
	sample_t         old_rmin_q;
	sample_t         old_rmax_q;
	logic [CW-1:0]   old_cnt_q;

	logic            out_valid_q;
	logic            kind_q;
	logic [BIN_OUT_W-1:0] bin_out_q;
	sample_t         ll_q;
	sample_t         lh_q;
	sample_t         rl_q;
	sample_t         rh_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;
	chan_t           chans_out_q;
	logic            last_q;

	logic [NW-1:0]   num;
	logic [POS_W:0]  trial;
	logic            q_bit;
	logic [POS_W:0]  diff;
	logic [QW:0]     quo_sh;
	logic [QW:0]     lo_sh;
	logic [QW-1:0]   bin_now;
	logic            change;
	sample_t         lmin_base, lmax_base, rmin_base, rmax_base;
	sample_t         lmin_new, lmax_new, rmin_new, rmax_new;
	logic            cnt_inc;
	logic [FW:0]     fse_inc;
	logic            int_hit;
	chan_t           chans;
	logic [QW+BIN_OUT_W-1:0] old_bin_w, cur_bin_w;
	logic [CW+CNT_OUT_W-1:0] old_cnt_w, cur_cnt_w;
	logic            out_free;
	logic            rec_load;

	always_comb begin
		num       = NW'(pos_q) * NW'(BIN_COUNT);
		trial     = {rem_q, lo_q[QW-1]};
		q_bit     = trial >= {1'b0, cap_q};
		diff      = trial - {1'b0, cap_q};
		quo_sh    = {quo_q, q_bit};
		lo_sh     = {lo_q, 1'b0};

		bin_now   = clamp_q ? QW'(BIN_COUNT - 1) : quo_q;
		change    = !active_q || (open_bin_q != bin_now);

		// A new bin starts from the empty extremes before taking the frame.
		lmin_base = change ? SAMPLE_MAX : lmin_q;
		lmax_base = change ? SAMPLE_MIN : lmax_q;
		rmin_base = change ? SAMPLE_MAX : rmin_q;
		rmax_base = change ? SAMPLE_MIN : rmax_q;
		lmin_new  = (l_q < lmin_base) ? l_q : lmin_base;
		lmax_new  = (l_q > lmax_base) ? l_q : lmax_base;
		rmin_new  = (r_q < rmin_base) ? r_q : rmin_base;
		rmax_new  = (r_q > rmax_base) ? r_q : rmax_base;

		cnt_inc   = change && (opened_q < CW'(BIN_COUNT));
		fse_inc   = {1'b0, fse_q} + (FW+1)'(1);
		int_hit   = fse_inc >= (FW+1)'(PUBLISH_INTERVAL);

		chans     = (chan_cfg_q == CHAN_MONO) ? CHAN_MONO : CHAN_STEREO;

		old_bin_w = {{BIN_OUT_W{1'b0}}, old_bin_q};
		cur_bin_w = {{BIN_OUT_W{1'b0}}, open_bin_q};
		old_cnt_w = {{CNT_OUT_W{1'b0}}, old_cnt_q};
		cur_cnt_w = {{CNT_OUT_W{1'b0}}, opened_q};

		out_free  = !out_valid_q || out_ready;
		rec_load  = (state_q == S_EMIT) && out_free && (pend_clr_q || pend_old_q || pend_int_q);
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	assign out_valid         = out_valid_q;
	assign record_kind       = kind_q;
	assign bin_index         = bin_out_q;
	assign left_low          = ll_q;
	assign left_high         = lh_q;
	assign right_low         = rl_q;
	assign right_high        = rh_q;
	assign valid_bin_count   = cnt_out_q;
	assign reported_channels = chans_out_q;
	assign last              = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= '0;
			chan_cfg_q  <= CHAN_STEREO;
			open_bin_q  <= '0;
			active_q    <= 1'b0;
			lmin_q      <= SAMPLE_MAX;
			lmax_q      <= SAMPLE_MIN;
			rmin_q      <= SAMPLE_MAX;
			rmax_q      <= SAMPLE_MIN;
			opened_q    <= '0;
			fse_q       <= '0;
			pend_clr_q  <= 1'b0;
			pend_old_q  <= 1'b0;
			pend_int_q  <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_CAPACITY: cap_q      <= cfg_data[POS_W-1:0];
					CFG_CHANNELS: chan_cfg_q <= cfg_data[CHAN_W-1:0];
					default: ;
				endcase
			end

			if (rec_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pos_q <= frame_offset;
						l_q   <= left_sample;
						r_q   <= right_sample;
						if (command == CMD_CLEAR) begin
							open_bin_q <= '0;
							active_q   <= 1'b0;
							lmin_q     <= SAMPLE_MAX;
							lmax_q     <= SAMPLE_MIN;
							rmin_q     <= SAMPLE_MAX;
							rmax_q     <= SAMPLE_MIN;
							opened_q   <= '0;
							fse_q      <= '0;
							pend_clr_q <= 1'b1;
							state_q    <= S_EMIT;
						end else if (frame_written && (cap_q != '0)) begin
							state_q <= S_MUL;
						end
					end
				end

				S_MUL: begin
					// Positions at or past capacity land in the last bin, so the
					// quotient otherwise stays below BIN_COUNT and fits QW bits.
					clamp_q <= pos_q >= cap_q;
					rem_q   <= num[NW-1:QW];
					lo_q    <= num[QW-1:0];
					quo_q   <= '0;
					step_q  <= SW'(QW);
					state_q <= S_DIV;
				end

				S_DIV: begin
					rem_q  <= q_bit ? diff[POS_W-1:0] : trial[POS_W-1:0];
					quo_q  <= quo_sh[QW-1:0];
					lo_q   <= lo_sh[QW-1:0];
					step_q <= step_q - SW'(1);
					if (step_q == SW'(1)) begin
						state_q <= S_UPD;
					end
				end

				S_UPD: begin
					old_bin_q  <= open_bin_q;
					old_lmin_q <= lmin_q;
					old_lmax_q <= lmax_q;
					old_rmin_q <= rmin_q;
					old_rmax_q <= rmax_q;
					old_cnt_q  <= opened_q;
					pend_old_q <= change && active_q;
					pend_int_q <= int_hit;

					open_bin_q <= bin_now;
					active_q   <= 1'b1;
					lmin_q     <= lmin_new;
					lmax_q     <= lmax_new;
					rmin_q     <= rmin_new;
					rmax_q     <= rmax_new;
					if (cnt_inc) begin
						opened_q <= opened_q + CW'(1);
					end
					fse_q <= int_hit ? '0 : fse_inc[FW-1:0];

					if ((change && active_q) || int_hit) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end

				S_EMIT: begin
					if (out_free) begin
						if (pend_clr_q) begin
							kind_q      <= REC_CLEAR;
							bin_out_q   <= '0;
							ll_q        <= '0;
							lh_q        <= '0;
							rl_q        <= '0;
							rh_q        <= '0;
							cnt_out_q   <= '0;
							chans_out_q <= chans;
							last_q      <= 1'b1;
							pend_clr_q  <= 1'b0;
							state_q     <= S_IDLE;
						end else if (pend_old_q) begin
							// The finished bin goes out first, with the count from
							// before the new bin was opened.
							kind_q      <= REC_BIN;
							bin_out_q   <= old_bin_w[BIN_OUT_W-1:0];
							ll_q        <= old_lmin_q;
							lh_q        <= old_lmax_q;
							rl_q        <= old_rmin_q;
							rh_q        <= old_rmax_q;
							cnt_out_q   <= old_cnt_w[CNT_OUT_W-1:0];
							chans_out_q <= chans;
							last_q      <= !pend_int_q;
							pend_old_q  <= 1'b0;
							if (!pend_int_q) begin
								state_q <= S_IDLE;
							end
						end else if (pend_int_q) begin
							kind_q      <= REC_BIN;
							bin_out_q   <= cur_bin_w[BIN_OUT_W-1:0];
							ll_q        <= lmin_q;
							lh_q        <= lmax_q;
							rl_q        <= rmin_q;
							rh_q        <= rmax_q;
							cnt_out_q   <= cur_cnt_w[CNT_OUT_W-1:0];
							chans_out_q <= chans;
							last_q      <= 1'b1;
							pend_int_q  <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
